@@ hw/rtl/shbs_pkg.sv @@
// shared types and constants of the string hash bin select block
// no dependencies; imported by shbs_ctrl, shbs_dp, string_hash_bin_select and the dv checker and testbench
package shbs_pkg;

  localparam int CHAR_W     = 8;
  localparam int HASH_W     = 32;
  localparam int BIN_W      = 31;
  localparam int DIV_CNT_W  = $clog2(HASH_W);
  localparam int HASH_SHIFT = 5;

  localparam logic [HASH_W-1:0]    HASH_SEED = HASH_W'(5381);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(HASH_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic hash_upd;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic char_zero;
    logic div_last;
  } sts_t;

endpackage

@@ hw/rtl/shbs_dp.sv @@
// datapath: running djb2 hash, bit-serial restoring divider, result register
// depends on shbs_pkg
module shbs_dp import shbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [BIN_W-1:0]  bin_count,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic [BIN_W-1:0]  bin_index
);

  logic [HASH_W-1:0]    hash;
  logic [HASH_W-1:0]    dvd;
  logic [HASH_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [BIN_W-1:0]     divisor;
  logic [HASH_W-1:0]    rem_shift;
  logic [HASH_W-1:0]    rem_sub;
  logic                 rem_ge;

  // a zero bin count acts as one
  assign divisor = (bin_count == '0) ? BIN_W'(1) : bin_count;

  assign rem_shift = {rem[HASH_W-2:0], dvd[HASH_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, divisor};
  assign rem_sub   = rem_shift - {1'b0, divisor};

  assign sts.char_zero = (char_code == '0);
  assign sts.div_last  = (cnt == DIV_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= HASH_SEED;
    end else if (cmd.div_start) begin
      hash <= HASH_SEED;
    end else if (cmd.hash_upd) begin
      hash <= (hash << HASH_SHIFT) + hash + HASH_W'(char_code);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd <= hash;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[HASH_W-2:0], 1'b0};
      rem <= rem_ge ? rem_sub : rem_shift;
      cnt <= cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bin_index <= rem[BIN_W-1:0];
    end
  end

endmodule

@@ hw/rtl/shbs_ctrl.sv @@
// controller: input/output handshakes and the divide sequence
// depends on shbs_pkg
module shbs_ctrl import shbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.char_zero) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end else begin
            cmd.hash_upd = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/string_hash_bin_select.sv @@
// top level of the string hash bin select block (djb2 hash, modulo bin count)
// depends on shbs_pkg, shbs_ctrl, shbs_dp
//
//   channel   dir  request                 fields
//   s_axis    in   one string byte         tdata[7:0] char_code
//   m_axis    out  one bin index           tdata[30:0] bin_index, [31] zero
//   cfg       in   bin count write         cfg_wdata[30:0] bin_count
//
// a nonzero byte is taken while the block is idle, so such bytes stream at one per cycle
// a zero byte starts 32 steps of the one-bit-per-cycle divider, then the result
// register is loaded once the output slot is free, then the next byte is taken
// the result register holds a bin index while the output stalls; a second
// terminator may finish its divide meanwhile and waits for the slot
// rst is synchronous: hash reloads 5381, bin count becomes 1, outputs empty
module string_hash_bin_select import shbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] bin_index, [31] zero
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata       // [30:0] bin_count
);

  logic [BIN_W-1:0] bin_count;
  logic [BIN_W-1:0] bin_index;
  cmd_t             cmd;
  sts_t             sts;

  // configuration register; the user must write it only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= BIN_W'(1);
    end else if (cfg_we) begin
      bin_count <= cfg_wdata;
    end
  end

  // state machine: handshakes and divide sequencing
  shbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hash, divider and result register
  shbs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_code (s_axis_tdata),
    .bin_count (bin_count),
    .cmd       (cmd),
    .sts       (sts),
    .bin_index (bin_index)
  );

  // pad the 31-bit index up to a whole byte count
  assign m_axis_tdata = {1'b0, bin_index};

`ifndef SYNTH
  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a terminator blocks input while the divider runs
  a_term_stalls: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_axis_tdata == '0) |=> !s_axis_tready)
    else $error("input taken right after a terminator");

  // a nonzero byte never creates a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_axis_tdata != '0 && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result appeared after a nonzero byte");

  // a shown index lies below the bin count (zero count acts as one)
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((bin_count == '0 && bin_index == '0) ||
                       (bin_count != '0 && bin_index < bin_count)))
    else $error("bin index out of range");

  // the result register is loaded only when its slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before it was taken");
`endif

endmodule

@@ dv/string_hash_bin_select_chk.sv @@
// checker for string_hash_bin_select: watches the byte, bin count and result channels
// depends on shbs_pkg; instantiated by string_hash_bin_select_tb beside the block
module string_hash_bin_select_chk import shbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [CHAR_W-1:0] s_axis_tdata,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [31:0]       m_axis_tdata,
  input  logic              cfg_we,
  input  logic [BIN_W-1:0]  cfg_wdata,
  output int                fail_count,
  output int                pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [HASH_W-1:0] run_hash;
  logic [BIN_W-1:0]  bin_count;
  logic [BIN_W-1:0]  pending_bins[$];

  function automatic logic [HASH_W-1:0] fold_char(input logic [HASH_W-1:0] h,
                                                  input logic [CHAR_W-1:0] c);
    return (h << 5) + h + HASH_W'(c);
  endfunction

  // a bin count of zero reduces like a bin count of one
  function automatic logic [BIN_W-1:0] bin_of(input logic [HASH_W-1:0] h,
                                              input logic [BIN_W-1:0] n);
    logic [HASH_W-1:0] d;
    d = (n == '0) ? HASH_W'(1) : HASH_W'(n);
    return BIN_W'(h % d);
  endfunction

  always @(posedge clk) begin : watch
    logic [BIN_W-1:0] want;
    if (rst) begin
      run_hash   = HASH_SEED;
      bin_count  = BIN_W'(1);
      fail_count = 0;
      pending_bins.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_bins.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected bin index %h", $realtime, m_axis_tdata);
        end else begin
          want = pending_bins.pop_front();
          if (m_axis_tdata !== {1'b0, want}) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: bin index mismatch, expected %h, got %h",
                       $realtime, {1'b0, want}, m_axis_tdata);
          end
        end
      end
      if (cfg_we)
        bin_count = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tdata != '0) begin
          run_hash = fold_char(run_hash, s_axis_tdata);
        end else begin
          pending_bins.push_back(bin_of(run_hash, bin_count));
          run_hash = HASH_SEED;
        end
      end
    end
    pending_count = pending_bins.size();
  end

endmodule

@@ dv/string_hash_bin_select_tb.sv @@
// testbench top for string_hash_bin_select: drives strings and bin count writes
// depends on shbs_pkg, string_hash_bin_select and string_hash_bin_select_chk
module string_hash_bin_select_tb import shbs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;    // room for a terminator's divide and result load, plus margin
  localparam int RANDOM_ITEMS = 1050;
  localparam int PHASES       = 8;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic [CHAR_W-1:0] s_axis_tdata = '0;
  logic              m_axis_tready = 1'b0;
  logic              cfg_we = 1'b0;
  logic [BIN_W-1:0]  cfg_wdata = '0;
  wire               s_axis_tready;
  wire               m_axis_tvalid;
  wire  [31:0]       m_axis_tdata;

  int          fail_count;
  int          pending_count;
  int unsigned cycles = 0;
  bit          calm = 1'b0;    // high: neither side idles

  string_hash_bin_select u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [7:0] char_code
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [30:0] bin_index, [31] zero
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)        // [30:0] bin_count
  );

  string_hash_bin_select_chk u_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side stalls about a quarter of the time, never while calm
  always @(posedge clk) begin
    if (rst)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= calm || ($urandom_range(99) >= 25);
  end

  // one byte request; random idle cycles ahead of it unless calm
  // tready is sampled mid-cycle, where valid and the block state are settled
  task automatic send_char(input logic [CHAR_W-1:0] c);
    logic took;
    while (!calm && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
  endtask

  // random nonzero bytes, extremes now and then, closed by the terminator
  task automatic send_string(input int len);
    int pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(9);
      if (pick == 0)
        send_char(8'hff);
      else if (pick == 1)
        send_char(8'h01);
      else
        send_char(CHAR_W'($urandom_range(1, 255)));
    end
    send_char('0);
  endtask

  // hold the byte channel until every bin index is back and the divider is quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // bin count writes only ever land on an idle block
  task automatic set_bins(input logic [BIN_W-1:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int               sent;
    int               len;
    bit               paused;
    logic [BIN_W-1:0] n;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset bin count of one: every string lands in bin zero
    send_char('0);                      // empty string
    send_char(8'h61);
    send_char(8'h62);
    send_char('0);

    // widest bin count: the raw hash mostly shows through
    set_bins('1);
    send_char('0);                      // empty string gives the seed
    send_char(8'hff);
    send_char('0);
    send_char(8'h01);
    send_char('0);
    send_char(8'h55);                   // four bytes already wrap the hash
    send_char(8'haa);
    send_char(8'h80);
    send_char(8'h7f);
    send_char('0);

    // bin count of zero behaves as one
    set_bins('0);
    send_char(8'h41);
    send_char('0);

    // random strings under several bin counts; phase 4 runs without idling
    paused = 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       n = BIN_W'(2);
        1:       n = BIN_W'(3);
        2:       n = BIN_W'(7);
        3:       n = BIN_W'($urandom_range(1, 1000));
        4:       n = BIN_W'(32'h4000_0000);
        5:       n = BIN_W'($urandom);
        6:       n = '1;
        default: n = BIN_W'(1);
      endcase
      set_bins(n);
      calm <= (phase == 4);
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_string(len);
        sent += len + 1;
        // sender holds off once, in phase 2, until all results are back
        if (phase == 2 && sent >= 60 && !paused) begin
          paused = 1'b1;
          drain();
        end
      end
    end
    calm <= 1'b0;

    drain();
    @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
